// ----- rtl/core/tlsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tlsd_pkg
// shared types and constants for the two-level sorted directory
// ----------------------------------------------------------------------------
`default_nettype none
package tlsd_pkg;

  localparam int MOD_SLOTS = 16;
  localparam int BOX_SLOTS = 64;
  localparam int MIDX_W    = $clog2(MOD_SLOTS);
  localparam int SIDX_W    = $clog2(BOX_SLOTS);
  localparam int MCNT_W    = $clog2(MOD_SLOTS + 1);
  localparam int SCNT_W    = $clog2(BOX_SLOTS + 1);
  localparam int ID_W      = 8;
  localparam int BOX_W     = 8;
  localparam int STAT_W    = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [STAT_W-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_MOD_FULL  = 3'd3,
    STAT_SLOT_FULL = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_BOX
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SCNT_W-1:0] first;
    logic [SCNT_W-1:0] count;
  } mod_ent_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic inc_first;
    logic inc_count;
  } mcell_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } scell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/tlsd_mod_cell.sv -----
// ----------------------------------------------------------------------------
// tlsd_mod_cell
// one module table entry: compares against a key, shifts from its neighbour
// ----------------------------------------------------------------------------
`default_nettype none
module tlsd_mod_cell (
  input  wire                   clk_i,
  input  wire                   valid_i,
  input  wire [tlsd_pkg::ID_W-1:0] key_i,
  input  tlsd_pkg::mcell_ctl_t  ctl_i,
  input  tlsd_pkg::mod_ent_t    left_i,
  input  tlsd_pkg::mod_ent_t    new_i,
  output tlsd_pkg::mod_ent_t    ent_o,
  output logic                  less_o,
  output logic                  eq_o
);
  import tlsd_pkg::*;

  mod_ent_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load) begin
      ent_d = new_i;
    end else if (ctl_i.shift) begin
      ent_d = left_i;
    end else begin
      ent_d.first = ent_q.first + SCNT_W'(ctl_i.inc_first);
      ent_d.count = ent_q.count + SCNT_W'(ctl_i.inc_count);
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o  = ent_q;
  assign less_o = valid_i && (ent_q.id < key_i);
  assign eq_o   = valid_i && (ent_q.id == key_i);

endmodule
`default_nettype wire

// ----- rtl/core/tlsd_slot_cell.sv -----
// ----------------------------------------------------------------------------
// tlsd_slot_cell
// one slot table entry: compares its box number, shifts from its neighbour
// ----------------------------------------------------------------------------
`default_nettype none
module tlsd_slot_cell (
  input  wire                       clk_i,
  input  wire                       in_run_i,
  input  wire [tlsd_pkg::BOX_W-1:0] key_i,
  input  tlsd_pkg::scell_ctl_t      ctl_i,
  input  wire [tlsd_pkg::BOX_W-1:0] left_i,
  output logic [tlsd_pkg::BOX_W-1:0] box_o,
  output logic                      below_o,
  output logic                      hit_o
);
  import tlsd_pkg::*;

  logic [BOX_W-1:0] box_q, box_d;

  always_comb begin
    box_d = box_q;
    if (ctl_i.load) begin
      box_d = key_i;
    end else if (ctl_i.shift) begin
      box_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o   = box_q;
  assign below_o = in_run_i && (box_q < key_i);
  assign hit_o   = in_run_i && (box_q == key_i);

endmodule
`default_nettype wire

// ----- rtl/core/two_level_sorted_directory.sv -----
// ----------------------------------------------------------------------------
// two_level_sorted_directory
// sorted module table and sorted box runs held in rows of compare/shift cells
// ----------------------------------------------------------------------------
// an input is registered, then runs the module pass and then the box pass
// before its result is registered; a new item is taken only when idle
// results wait in an output register; a stalled output holds the box pass
// reset clears the fill counts, state machine and output valid only
// ----------------------------------------------------------------------------
`default_nettype none
module two_level_sorted_directory (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,  // module_id, box_number
  input  wire  [0:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata   // status, slot_index, module_index, pad
);
  import tlsd_pkg::*;

  state_e state_q, state_d;
  logic [ID_W-1:0]   key_id_q;
  logic [BOX_W-1:0]  key_box_q;
  logic              kind_q;
  logic [MCNT_W-1:0] mods_used_q, mods_used_d;
  logic [SCNT_W-1:0] slots_used_q, slots_used_d;
  logic [MIDX_W-1:0] midx_q, midx_d;
  logic              abort_q, abort_d;
  logic [STAT_W-1:0] abort_stat_q, abort_stat_d;
  logic              out_valid_q;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic [SIDX_W-1:0] out_slot_q, out_slot_d;
  logic [MIDX_W-1:0] out_mod_q, out_mod_d;

  mod_ent_t   ments [MOD_SLOTS];
  mcell_ctl_t mctl  [MOD_SLOTS];
  logic [MOD_SLOTS-1:0] mless, meq, mvalid;
  mod_ent_t   mnew;

  logic [BOX_W-1:0] sbox [BOX_SLOTS];
  scell_ctl_t sctl [BOX_SLOTS];
  logic [BOX_SLOTS-1:0] sbelow, shit, sinrun;

  logic              accept, advance, mod_ins, box_ins;
  logic [MCNT_W-1:0] mpos;
  logic              mfound;
  mod_ent_t          msel;
  logic [SCNT_W:0]   run_end;
  logic [SIDX_W-1:0] hit_idx, ins_idx;
  logic              bfound;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign advance = (state_q == ST_BOX) && (!out_valid_q || m_axis_tready);

  // module cells
  for (genvar i = 0; i < MOD_SLOTS; i++) begin : g_mcell
    assign mvalid[i] = MCNT_W'(i) < mods_used_q;
    tlsd_mod_cell u_cell (
      .clk_i  (clk_i),
      .valid_i(mvalid[i]),
      .key_i  (key_id_q),
      .ctl_i  (mctl[i]),
      .left_i ((i == 0) ? mnew : ments[(i == 0) ? 0 : i-1]),
      .new_i  (mnew),
      .ent_o  (ments[i]),
      .less_o (mless[i]),
      .eq_o   (meq[i])
    );
  end

  // slot cells
  for (genvar j = 0; j < BOX_SLOTS; j++) begin : g_scell
    assign sinrun[j] = ((SCNT_W+1)'(j) >= {1'b0, msel.first}) &&
                       ((SCNT_W+1)'(j) < run_end);
    tlsd_slot_cell u_cell (
      .clk_i   (clk_i),
      .in_run_i(sinrun[j]),
      .key_i   (key_box_q),
      .ctl_i   (sctl[j]),
      .left_i  (sbox[(j == 0) ? 0 : j-1]),
      .box_o   (sbox[j]),
      .below_o (sbelow[j]),
      .hit_o   (shit[j])
    );
  end

  // module search
  always_comb begin
    mpos = MCNT_W'(MOD_SLOTS);
    for (int i = MOD_SLOTS-1; i >= 0; i--) begin
      if (!mless[i]) mpos = MCNT_W'(i);
    end
  end
  assign mfound = |meq;

  always_comb begin
    mnew.id    = key_id_q;
    mnew.count = '0;
    mnew.first = (mpos == mods_used_q) ? slots_used_q : ments[mpos[MIDX_W-1:0]].first;
  end

  // box search
  assign msel    = ments[midx_q];
  assign run_end = {1'b0, msel.first} + {1'b0, msel.count};

  always_comb begin
    hit_idx = '0;
    ins_idx = '0;
    for (int j = BOX_SLOTS-1; j >= 0; j--) begin
      if (shit[j]) hit_idx = SIDX_W'(j);
      if (((SCNT_W)'(j) >= msel.first) && !sbelow[j]) ins_idx = SIDX_W'(j);
    end
  end
  assign bfound = |shit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MOD;
      ST_MOD:  state_d = ST_BOX;
      ST_BOX:  if (advance) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mod_ins      = 1'b0;
    box_ins      = 1'b0;
    midx_d       = midx_q;
    abort_d      = abort_q;
    abort_stat_d = abort_stat_q;
    mods_used_d  = mods_used_q;
    slots_used_d = slots_used_q;
    out_stat_d   = out_stat_q;
    out_slot_d   = out_slot_q;
    out_mod_d    = out_mod_q;
    case (state_q)
      ST_MOD: begin
        abort_d = 1'b0;
        midx_d  = mpos[MIDX_W-1:0];
        if (!mfound) begin
          if (!kind_q) begin
            abort_d      = 1'b1;
            abort_stat_d = STAT_NOT_FOUND;
            midx_d       = '0;
          end else if (mods_used_q >= MCNT_W'(MOD_SLOTS)) begin
            abort_d      = 1'b1;
            abort_stat_d = STAT_MOD_FULL;
            midx_d       = '0;
          end else begin
            mod_ins     = 1'b1;
            mods_used_d = mods_used_q + MCNT_W'(1);
          end
        end
      end
      ST_BOX: begin
        if (advance) begin
          out_mod_d  = midx_q;
          out_slot_d = '0;
          if (abort_q) begin
            out_stat_d = abort_stat_q;
            out_mod_d  = '0;
          end else if (bfound) begin
            out_stat_d = STAT_FOUND;
            out_slot_d = hit_idx;
          end else if (!kind_q) begin
            out_stat_d = STAT_NOT_FOUND;
          end else if (slots_used_q >= SCNT_W'(BOX_SLOTS)) begin
            out_stat_d = STAT_SLOT_FULL;
          end else begin
            out_stat_d   = STAT_INSERTED;
            out_slot_d   = ins_idx;
            box_ins      = 1'b1;
            slots_used_d = slots_used_q + SCNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MOD_SLOTS; i++) begin
      mctl[i].load      = mod_ins && (MCNT_W'(i) == mpos);
      mctl[i].shift     = mod_ins && (MCNT_W'(i) > mpos);
      mctl[i].inc_first = box_ins && (MIDX_W'(i) > midx_q);
      mctl[i].inc_count = box_ins && (MIDX_W'(i) == midx_q);
    end
    for (int j = 0; j < BOX_SLOTS; j++) begin
      sctl[j].load  = box_ins && (SIDX_W'(j) == ins_idx);
      sctl[j].shift = box_ins && (SIDX_W'(j) > ins_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mods_used_q  <= '0;
      slots_used_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mods_used_q  <= mods_used_d;
      slots_used_q <= slots_used_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= s_axis_tuser[0];
      key_id_q  <= s_axis_tdata[7:0];
      key_box_q <= s_axis_tdata[15:8];
    end
    midx_q       <= midx_d;
    abort_q      <= abort_d;
    abort_stat_q <= abort_stat_d;
    out_stat_q   <= out_stat_d;
    out_slot_q   <= out_slot_d;
    out_mod_q    <= out_mod_d;
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
  end
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_mod_q, out_slot_q, out_stat_q};

`ifndef ASSERT_OFF
  a_mods_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mods_used_q <= MCNT_W'(MOD_SLOTS)) else $error("module count overflow");
  a_slots_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_used_q <= SCNT_W'(BOX_SLOTS)) else $error("slot count overflow");
  a_out_after_box : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_BOX)) else $error("result without box pass");
  a_slot_ins_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_ins |=> slots_used_q == $past(slots_used_q) + SCNT_W'(1))
    else $error("slot count slip");
`endif

endmodule
`default_nettype wire
